FILE: rtl/cfw_pkg.sv
// ----------------------------------------------------------------------------
// cfw_pkg
// Shared constants, register indexes and cosine table for the card flip wipe.
// ----------------------------------------------------------------------------
package cfw_pkg;

    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 256;
    localparam int unsigned MAX_CARDS  = 50;
    localparam int unsigned MIN_CARDS  = 2;

    localparam int unsigned CFG_DW = 16;
    localparam int unsigned CFG_IW = 3;
    localparam int unsigned PIX_W  = 32;
    localparam int unsigned MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam logic [14:0] TILT_CAP  = 15'd23040;
    localparam logic [15:0] TIME_CAP  = 16'd32768;
    localparam logic [14:0] ANGLE_MIN = 15'd147;
    localparam logic [15:0] COS_ONE   = 16'd32768;

    typedef enum logic [CFG_IW-1:0] {
        REG_CARD_COUNT = 3'd0,
        REG_FLIP_ORDER = 3'd1,
        REG_TILT       = 3'd2,
        REG_TIME       = 3'd3,
        REG_WIDTH      = 3'd4,
        REG_HEIGHT     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ORDER_LTR    = 2'd0,
        ORDER_RTL    = 2'd1,
        ORDER_CENTER = 2'd2,
        ORDER_NONE   = 2'd3
    } order_t;

    localparam logic [15:0] COS_TBL [0:90] = '{
        16'd32768, 16'd32763, 16'd32748, 16'd32723, 16'd32688, 16'd32643, 16'd32588,
        16'd32524, 16'd32449, 16'd32365, 16'd32270, 16'd32166, 16'd32052, 16'd31928,
        16'd31795, 16'd31651, 16'd31499, 16'd31336, 16'd31164, 16'd30983, 16'd30792,
        16'd30592, 16'd30382, 16'd30163, 16'd29935, 16'd29698, 16'd29452, 16'd29197,
        16'd28932, 16'd28660, 16'd28378, 16'd28088, 16'd27789, 16'd27482, 16'd27166,
        16'd26842, 16'd26510, 16'd26170, 16'd25822, 16'd25466, 16'd25102, 16'd24730,
        16'd24351, 16'd23965, 16'd23571, 16'd23170, 16'd22763, 16'd22348, 16'd21926,
        16'd21498, 16'd21063, 16'd20622, 16'd20174, 16'd19720, 16'd19261, 16'd18795,
        16'd18324, 16'd17847, 16'd17364, 16'd16877, 16'd16384, 16'd15886, 16'd15384,
        16'd14876, 16'd14365, 16'd13848, 16'd13328, 16'd12803, 16'd12275, 16'd11743,
        16'd11207, 16'd10668, 16'd10126, 16'd9580,  16'd9032,  16'd8481,  16'd7927,
        16'd7371,  16'd6813,  16'd6252,  16'd5690,  16'd5126,  16'd4560,  16'd3993,
        16'd3425,  16'd2856,  16'd2286,  16'd1715,  16'd1144,  16'd572,   16'd0
    };

    function automatic logic [15:0] cos_lut(input logic [7:0] idx);
        logic [15:0] val;
        val = 16'd0;
        if (idx <= 8'd90)
        begin
            val = COS_TBL[idx[6:0]];
        end
        return val;
    endfunction

endpackage

FILE: rtl/cfw_ram.sv
// ----------------------------------------------------------------------------
// cfw_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cfw_ram #(
    parameter int unsigned DW    = 32,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DW-1:0]            wdata,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cfw_div.sv
// ----------------------------------------------------------------------------
// cfw_div
// Pipelined restoring divider, one quotient bit per stage, side payload.
// ----------------------------------------------------------------------------
module cfw_div #(
    parameter int unsigned DW = 16,
    parameter int unsigned VW = 8,
    parameter int unsigned QW = 8,
    parameter int unsigned PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [PW-1:0] pay_in,
    output logic          vld_out,
    output logic [QW-1:0] quot,
    output logic [PW-1:0] pay_out
);

    localparam int unsigned RW = DW + VW + QW;

    logic          vld_reg [QW];
    logic [RW-1:0] rem_reg [QW];
    logic [VW-1:0] dvs_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [PW-1:0] pay_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int unsigned K = QW - 1 - s;
        logic          vld_in_s;
        logic [RW-1:0] rem_in;
        logic [VW-1:0] dvs_in;
        logic [QW-1:0] q_in;
        logic [PW-1:0] pay_in_s;
        logic [RW-1:0] sub;
        logic          ge;

        if (s == 0)
        begin : g_first
            assign vld_in_s = vld_in;
            assign rem_in   = RW'(dividend);
            assign dvs_in   = divisor;
            assign q_in     = '0;
            assign pay_in_s = pay_in;
        end
        else
        begin : g_next
            assign vld_in_s = vld_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign dvs_in   = dvs_reg[s-1];
            assign q_in     = q_reg[s-1];
            assign pay_in_s = pay_reg[s-1];
        end

        assign sub = RW'(dvs_in) << K;
        assign ge  = rem_in >= sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in_s;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? rem_in - sub : rem_in;
                dvs_reg[s] <= dvs_in;
                q_reg[s]   <= q_in | (QW'(ge) << K);
                pay_reg[s] <= pay_in_s;
            end
        end
    end

    assign vld_out = vld_reg[QW-1];
    assign quot    = q_reg[QW-1];
    assign pay_out = pay_reg[QW-1];

endmodule

FILE: rtl/card_flip_wipe_remap.sv
// ----------------------------------------------------------------------------
// card_flip_wipe_remap
// Card flip wipe over one stored RGBA frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): mode 0 stores pixel in_* at
//   (pos_x, pos_y); mode 1 requests an output pixel at (pos_x, pos_y).
//   Output channel (out_valid/out_stall): one pixel per produce request,
//   none per store, in request order.
//   Config port: cfg_write/cfg_index/cfg_data, write only while idle.
// Timing:
//   One request per cycle while not stalled. From acceptance to out_valid a
//   request passes three pipelined dividers (6, 16 and 8 stages),
//   multiply and cosine stages, and the frame RAM read.
//   Stores and reads hit the frame RAM at the same stage, so order holds.
// Reset:
//   Clears the pipeline and loads register defaults; frame RAM is undefined
//   until written.
// Stall:
//   While out_valid is held by out_stall the whole pipeline freezes and
//   in_stall is raised.
// ----------------------------------------------------------------------------
module card_flip_wipe_remap (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cfw_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [cfw_pkg::CFG_DW-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [7:0]                          pos_x,
    input  logic [7:0]                          pos_y,
    input  logic [7:0]                          in_red,
    input  logic [7:0]                          in_green,
    input  logic [7:0]                          in_blue,
    input  logic [7:0]                          in_alpha,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          out_red,
    output logic [7:0]                          out_green,
    output logic [7:0]                          out_blue,
    output logic [7:0]                          out_alpha
);

    typedef struct packed {
        logic        mode;
        logic        inframe;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] pix;
    } item_t;

    typedef struct packed {
        item_t       item;
        logic [13:0] xn;
    } pay1_t;

    typedef struct packed {
        item_t       item;
        logic [14:0] a;
        logic [14:0] nx2;
        logic        pos;
        logic        cap;
    } pay2_t;

    typedef struct packed {
        item_t       item;
        logic        remap;
    } pay3_t;

    // config
    logic [5:0]  card_count_reg;
    logic [1:0]  flip_order_reg;
    logic [14:0] tilt_reg;
    logic [15:0] time_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_count_reg <= 6'd5;
            flip_order_reg <= cfw_pkg::ORDER_LTR;
            tilt_reg       <= cfw_pkg::TILT_CAP;
            time_reg       <= 16'd0;
            width_reg      <= 9'(cfw_pkg::MAX_WIDTH);
            height_reg     <= 9'(cfw_pkg::MAX_HEIGHT);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cfw_pkg::REG_CARD_COUNT: card_count_reg <= cfg_data[5:0];
                cfw_pkg::REG_FLIP_ORDER: flip_order_reg <= cfg_data[1:0];
                cfw_pkg::REG_TILT:       tilt_reg       <= cfg_data[14:0];
                cfw_pkg::REG_TIME:       time_reg       <= cfg_data;
                cfw_pkg::REG_WIDTH:      width_reg      <= cfg_data[8:0];
                cfw_pkg::REG_HEIGHT:     height_reg     <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic [5:0]  n;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [15:0] t;
    logic [14:0] tilt;

    assign n = (card_count_reg < 6'(cfw_pkg::MIN_CARDS)) ? 6'(cfw_pkg::MIN_CARDS) :
               (card_count_reg > 6'(cfw_pkg::MAX_CARDS)) ? 6'(cfw_pkg::MAX_CARDS) :
               card_count_reg;
    assign w = (width_reg > 9'(cfw_pkg::MAX_WIDTH)) ? 9'(cfw_pkg::MAX_WIDTH) : width_reg;
    assign h = (height_reg > 9'(cfw_pkg::MAX_HEIGHT)) ? 9'(cfw_pkg::MAX_HEIGHT) : height_reg;
    assign t = (time_reg > cfw_pkg::TIME_CAP) ? cfw_pkg::TIME_CAP : time_reg;
    assign tilt = (tilt_reg > cfw_pkg::TILT_CAP) ? cfw_pkg::TILT_CAP : tilt_reg;

    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // S0: input register
    logic  s0_valid_reg;
    item_t s0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg.mode    <= mode;
            s0_reg.inframe <= 1'b0;
            s0_reg.x       <= pos_x;
            s0_reg.y       <= pos_y;
            s0_reg.pix     <= {in_alpha, in_blue, in_green, in_red};
        end
    end

    // column divider
    pay1_t d1_in;
    pay1_t d1_out;
    logic  d1_vld;
    logic [5:0] d1_q;

    always_comb
    begin
        d1_in              = '0;
        d1_in.item         = s0_reg;
        d1_in.item.inframe = ({1'b0, s0_reg.x} < w) && ({1'b0, s0_reg.y} < h);
        d1_in.xn           = 14'(s0_reg.x) * 14'(n);
    end

    cfw_div #(.DW(14), .VW(9), .QW(6), .PW($bits(pay1_t))) u_div_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (s0_valid_reg),
        .dividend (d1_in.xn),
        .divisor  (w),
        .pay_in   (d1_in),
        .vld_out  (d1_vld),
        .quot     (d1_q),
        .pay_out  (d1_out)
    );

    // S2: delay numerator and source terms
    logic [5:0]  col;
    logic [6:0]  col2;
    logic [6:0]  cdist;
    logic [5:0]  p_next;
    logic [14:0] cw;

    assign col   = (d1_q > n - 6'd1) ? n - 6'd1 : d1_q;
    assign col2  = {col, 1'b0};
    assign cdist = (col2 >= 7'(n)) ? col2 - 7'(n) : 7'(n) - col2;
    assign cw    = 15'(col) * 15'(w);

    always_comb
    begin
        case (flip_order_reg)
            cfw_pkg::ORDER_LTR:    p_next = col;
            cfw_pkg::ORDER_RTL:    p_next = n - col;
            cfw_pkg::ORDER_CENTER: p_next = 6'(7'(n) - cdist);
            default:               p_next = 6'd0;
        endcase
    end

    logic        s2_valid_reg;
    item_t       s2_item_reg;
    logic [14:0] s2_a_reg;
    logic [14:0] s2_nx2_reg;
    logic [20:0] s2_tn_reg;
    logic [5:0]  s2_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_item_reg <= d1_out.item;
            s2_a_reg    <= {cw[13:0], 1'b0} + 15'(w);
            s2_nx2_reg  <= {d1_out.xn, 1'b0};
            s2_tn_reg   <= 21'(t) * 21'(n);
            s2_p_reg    <= p_next;
        end
    end

    // S3: flip fraction numerator
    logic [20:0] pq;
    logic [20:0] dsub;
    pay2_t       s3_next;
    logic [23:0] dv_next;

    assign pq   = {1'b0, s2_p_reg, 14'd0};
    assign dsub = s2_tn_reg - pq;

    always_comb
    begin
        dv_next      = {dsub, 3'd0};
        s3_next.item = s2_item_reg;
        s3_next.a    = s2_a_reg;
        s3_next.nx2  = s2_nx2_reg;
        s3_next.pos  = s2_tn_reg > pq;
        s3_next.cap  = dv_next >= {2'd0, n, 16'd0};
    end

    logic        s3_valid_reg;
    pay2_t       s3_reg;
    logic [23:0] s3_dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg    <= s3_next;
            s3_dv_reg <= dv_next;
        end
    end

    pay2_t       d2_out;
    logic        d2_vld;
    logic [15:0] d2_q;

    cfw_div #(.DW(24), .VW(6), .QW(16), .PW($bits(pay2_t))) u_div_frac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (s3_valid_reg),
        .dividend (s3_dv_reg),
        .divisor  (n),
        .pay_in   (s3_reg),
        .vld_out  (d2_vld),
        .quot     (d2_q),
        .pay_out  (d2_out)
    );

    // S4: fraction Q16
    logic [16:0] frac_next;
    assign frac_next = !d2_out.pos ? 17'd0 : d2_out.cap ? 17'h10000 : {1'b0, d2_q};

    logic        s4_valid_reg;
    pay2_t       s4_reg;
    logic [16:0] s4_frac_reg;

    // S5: angle
    logic [31:0] ang_prod;
    logic        s5_valid_reg;
    pay2_t       s5_reg;
    logic [14:0] s5_angle_reg;

    assign ang_prod = 32'(s4_frac_reg) * 32'(tilt);

    // S6: cosine table
    logic        s6_valid_reg;
    pay2_t       s6_reg;
    logic [15:0] s6_c0_reg;
    logic [15:0] s6_c1_reg;
    logic [7:0]  s6_f_reg;
    logic        s6_remap_reg;

    // S7: interpolated cosine
    logic [25:0] cos_sum;
    logic        s7_valid_reg;
    pay2_t       s7_reg;
    logic [15:0] s7_c_reg;
    logic        s7_remap_reg;

    assign cos_sum = 26'(s6_c0_reg) * 26'(9'd256 - 9'(s6_f_reg))
                   + 26'(s6_c1_reg) * 26'(s6_f_reg) + 26'd128;

    // S8: blend products
    logic [15:0] omc;
    logic        s8_valid_reg;
    pay3_t       s8_reg;
    logic [30:0] s8_m1_reg;
    logic [30:0] s8_m2_reg;

    assign omc = cfw_pkg::COS_ONE - s7_c_reg;

    // S9: sum, scaled down by 32768
    logic [31:0] num;
    logic        s9_valid_reg;
    pay3_t       s9_reg;
    logic [16:0] s9_num_reg;

    assign num = 32'(s8_m1_reg) + 32'(s8_m2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= d2_vld;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg       <= d2_out;
            s4_frac_reg  <= frac_next;
            s5_reg       <= s4_reg;
            s5_angle_reg <= ang_prod[30:16];
            s6_reg       <= s5_reg;
            s6_c0_reg    <= cfw_pkg::cos_lut({1'b0, s5_angle_reg[14:8]});
            s6_c1_reg    <= cfw_pkg::cos_lut(8'(s5_angle_reg[14:8]) + 8'd1);
            s6_f_reg     <= s5_angle_reg[7:0];
            s6_remap_reg <= s5_angle_reg >= cfw_pkg::ANGLE_MIN;
            s7_reg       <= s6_reg;
            s7_c_reg     <= cos_sum[23:8];
            s7_remap_reg <= s6_remap_reg;
            s8_reg.item  <= s7_reg.item;
            s8_reg.remap <= s7_remap_reg;
            s8_m1_reg    <= 31'(s7_reg.a) * 31'(omc);
            s8_m2_reg    <= 31'(s7_reg.nx2) * 31'(s7_c_reg);
            s9_reg       <= s8_reg;
            s9_num_reg   <= num[31:15];
        end
    end

    pay3_t      d3_out;
    logic       d3_vld;
    logic [7:0] d3_q;

    cfw_div #(.DW(17), .VW(7), .QW(8), .PW($bits(pay3_t))) u_div_src (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (s9_valid_reg),
        .dividend (s9_num_reg),
        .divisor  ({n, 1'b0}),
        .pay_in   (s9_reg),
        .vld_out  (d3_vld),
        .quot     (d3_q),
        .pay_out  (d3_out)
    );

    // S10: frame address
    logic [8:0] wm1;
    logic [8:0] src_next;

    assign wm1      = w - 9'd1;
    assign src_next = !d3_out.remap ? {1'b0, d3_out.item.x} :
                      ({1'b0, d3_q} > wm1) ? wm1 : {1'b0, d3_q};

    logic        s10_valid_reg;
    logic        s10_mode_reg;
    logic        s10_inframe_reg;
    logic [15:0] s10_addr_reg;
    logic [31:0] s10_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s10_valid_reg <= d3_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s10_mode_reg    <= d3_out.item.mode;
            s10_inframe_reg <= d3_out.item.inframe;
            s10_addr_reg    <= d3_out.item.mode ? {d3_out.item.y, src_next[7:0]}
                                                : {d3_out.item.y, d3_out.item.x};
            s10_pix_reg     <= d3_out.item.pix;
        end
    end

    logic [31:0] rdata;

    cfw_ram #(.DW(cfw_pkg::PIX_W), .DEPTH(cfw_pkg::MEM_DEPTH)) u_frame (
        .clk   (clk),
        .en    (adv),
        .we    (s10_valid_reg && !s10_mode_reg),
        .addr  (s10_addr_reg),
        .wdata (s10_pix_reg),
        .rdata (rdata)
    );

    // S11: output
    logic out_valid_reg;
    logic out_inframe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s10_valid_reg && s10_mode_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_inframe_reg <= s10_inframe_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_inframe_reg ? rdata[7:0]   : 8'd0;
    assign out_green = out_inframe_reg ? rdata[15:8]  : 8'd0;
    assign out_blue  = out_inframe_reg ? rdata[23:16] : 8'd0;
    assign out_alpha = out_inframe_reg ? rdata[31:24] : 8'd0;

`ifndef SYNTHESIS
    a_frac_cap: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> s4_frac_reg <= 17'h10000)
        else $error("flip fraction above one");

    a_angle_cap: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> s5_angle_reg <= cfw_pkg::TILT_CAP)
        else $error("flip angle above tilt cap");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        s7_valid_reg |-> s7_c_reg <= cfw_pkg::COS_ONE)
        else $error("cosine out of range");

    a_src_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (d3_vld && d3_out.item.mode && d3_out.item.inframe) |-> src_next < w)
        else $error("source column outside frame");
`endif

endmodule
